// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the range-sum prefix table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define RSPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RSPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rspt_pkg.sv
// Shared types and constants for the range-sum prefix table.
// No dependencies.
package rspt_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 64;
  localparam int unsigned IDX_W            = 6;
  localparam int unsigned WORD_W           = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Command token that walks the cell chain, one cell per cycle while the chain is not stalled.
  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic               ok;      // passed entry checks, cells may act
    logic               placed;  // append already stored by some cell
    logic [IDX_W-1:0]   first;
    logic [IDX_W-1:0]   last;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  delta;   // update difference, set at the target cell
    logic [WORD_W-1:0]  run;     // prefix sum of all cells before this one
    logic [WORD_W-1:0]  acc;     // query result under construction
    status_e            status;
  } token_t;

endpackage

// File: sv/range_sum_prefix_table_unit.sv
// Range-sum prefix table: top level with entry checks and the cell chain.
// Depends on rspt_pkg and rspt_cell.
//
// Usage
//   Input stream s_*: s_tuser carries the command (append, update, query),
//   s_tdata carries first_index, last_index and value. Output stream m_*:
//   one result transfer per input transfer, in order, carrying range_sum
//   and status.
//   Each command enters a token register, then walks a chain of
//   MAX_ELEMENTS cells, one cell per cycle while the chain is not
//   stalled. Cell k holds element k and prefix entry k+1; an update adds
//   its difference as it passes the later cells, a query collects
//   prefix[last+1] - prefix[first] on its way. The result is registered
//   in the entry token register and then in each cell's token register
//   in turn; the chain is a pipeline, so one transfer per cycle is taken
//   when the output side keeps up.
//   The last cell's token register is the output register. When the
//   receiver stalls, the whole chain and s_tready hold until it takes
//   the result; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the table and drops all tokens in
//   flight, with no clearing pass.
module range_sum_prefix_table_unit import rspt_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  input  logic [47:0] s_tdata,   // [5:0] first_index, [11:6] last_index,
                                 // [43:12] value, [47:44] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] range_sum, [33:32] status,
                                 // [39:34] zero
);

  localparam int unsigned CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0] count;
  token_t        tok_entry;
  token_t        tok_chain [MAX_ELEMENTS];

  logic          en;
  logic          accept;
  cmd_e          in_cmd;
  logic [CMPW-1:0] f_ext, l_ext, c_ext;
  logic          in_ok;
  status_e       in_status;

  // Whole chain advances unless a finished result is waiting.
  assign en       = !tok_chain[MAX_ELEMENTS-1].valid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  assign in_cmd = cmd_e'(s_tuser);
  assign f_ext  = CMPW'(s_tdata[5:0]);
  assign l_ext  = CMPW'(s_tdata[11:6]);
  assign c_ext  = CMPW'(count);

  // Entry checks against the running count.
  always_comb begin
    in_ok     = 1'b0;
    in_status = ST_BAD;
    case (in_cmd)
      CMD_APPEND: begin
        if (count == CW'(MAX_ELEMENTS)) begin
          in_status = ST_FULL;
        end else begin
          in_ok     = 1'b1;
          in_status = ST_OK;
        end
      end
      CMD_UPDATE: begin
        if (f_ext < c_ext) begin
          in_ok     = 1'b1;
          in_status = ST_OK;
        end
      end
      CMD_QUERY: begin
        if (f_ext < c_ext && l_ext < c_ext && f_ext <= l_ext) begin
          in_ok     = 1'b1;
          in_status = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      tok_entry.valid <= 1'b0;
    end else if (en) begin
      if (accept && in_ok && in_cmd == CMD_APPEND) begin
        count <= count + CW'(1);
      end
      tok_entry.valid  <= accept;
      tok_entry.cmd    <= in_cmd;
      tok_entry.ok     <= in_ok;
      tok_entry.placed <= 1'b0;
      tok_entry.first  <= s_tdata[5:0];
      tok_entry.last   <= s_tdata[11:6];
      tok_entry.value  <= s_tdata[43:12];
      tok_entry.delta  <= '0;
      tok_entry.run    <= '0;
      tok_entry.acc    <= '0;
      tok_entry.status <= in_status;
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      rspt_cell #(.IDX(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .tok_in  (tok_entry),
        .tok_out (tok_chain[i])
      );
    end else begin : g_body
      rspt_cell #(.IDX(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .tok_in  (tok_chain[i-1]),
        .tok_out (tok_chain[i])
      );
    end
  end

  // acc stays zero for everything but a good query.
  assign m_tvalid = tok_chain[MAX_ELEMENTS-1].valid;
  assign m_tdata  = {6'b0, tok_chain[MAX_ELEMENTS-1].status, tok_chain[MAX_ELEMENTS-1].acc};

endmodule

// File: sv/rspt_cell.sv
// One cell of the prefix table chain: holds element IDX and prefix entry IDX+1.
// Depends on rspt_pkg.
module rspt_cell import rspt_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  token_t tok_in,
  output token_t tok_out
);

  localparam int unsigned IW = (IDX > 63) ? $clog2(IDX + 1) : IDX_W;

  logic [WORD_W-1:0] elem;
  logic [WORD_W-1:0] pref;
  logic              filled;

  logic [WORD_W-1:0] elem_next;
  logic [WORD_W-1:0] pref_next;
  logic              filled_next;
  token_t            tok_next;

  logic              act;
  logic              is_first;
  logic              is_last;
  logic              after_first;
  logic [WORD_W-1:0] diff;

  assign act         = tok_in.valid && tok_in.ok;
  assign is_first    = IW'(tok_in.first) == IW'(IDX);
  assign is_last     = IW'(tok_in.last) == IW'(IDX);
  assign after_first = IW'(IDX) > IW'(tok_in.first);
  assign diff        = tok_in.value - elem;

  always_comb begin
    elem_next   = elem;
    pref_next   = pref;
    filled_next = filled;
    tok_next    = tok_in;
    if (act) begin
      case (tok_in.cmd)
        CMD_APPEND: begin
          if (!tok_in.placed && !filled) begin
            elem_next       = tok_in.value;
            pref_next       = tok_in.run + tok_in.value;
            filled_next     = 1'b1;
            tok_next.placed = 1'b1;
          end
        end
        CMD_UPDATE: begin
          if (is_first) begin
            elem_next      = tok_in.value;
            pref_next      = pref + diff;
            tok_next.delta = diff;
          end else if (after_first && filled) begin
            pref_next = pref + tok_in.delta;
          end
        end
        CMD_QUERY: begin
          tok_next.acc = tok_in.acc + (is_last ? pref : '0) - (is_first ? tok_in.run : '0);
        end
        default: begin
        end
      endcase
    end
    tok_next.run = pref_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled        <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      filled  <= filled_next;
      elem    <= elem_next;
      pref    <= pref_next;
      tok_out <= tok_next;
    end
  end

endmodule

// File: sv/rspt_checker.sv
// Port-level checks for the range-sum prefix table, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rspt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `RSPT_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `RSPT_ASSERT(a_stall_back, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
  `RSPT_ASSERT(a_status_code, clk, rst, m_tvalid |-> m_tdata[33:32] != 2'd3, "unused status code")
  `RSPT_ASSERT(a_flag_zero, clk, rst, m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0, "flagged result has nonzero sum")
  `RSPT_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "result shown right after reset")

endmodule

bind range_sum_prefix_table_unit rspt_checker u_rspt_checker (.*);
